// ===== design/dsa_pkg.sv =====
package dsa_pkg;

    // table geometry
    localparam int TABLE_SLOTS      = 256;
    localparam int FIRST_ALLOC_SLOT = 3;
    localparam int GROUP_BITS       = 16;
    localparam int GROUP_IDX_W      = $clog2(GROUP_BITS);
    localparam int GROUPS           = (TABLE_SLOTS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int GRP_W            = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PAD_SLOT_W       = GRP_W + GROUP_IDX_W;
    localparam int SLOT_W           = $clog2(TABLE_SLOTS);

    // field widths
    localparam int HANDLE_W   = 64;
    localparam int DESC_W     = 10;
    localparam int INDEX_W    = 9;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 80;

    typedef logic [GROUP_BITS-1:0] group_word_t;
    typedef logic [GRP_W-1:0]      group_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_FREE   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STD_INPUT  = 2'd0,
        CFG_STD_OUTPUT = 2'd1,
        CFG_STD_ERROR  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic                   found;
        logic [GROUP_IDX_W-1:0] idx;
    } zero_find_t;

    // bits of a group that allocate must never pick: fixed slots and padding
    function automatic group_word_t blocked_mask(group_idx_t grp);
        group_word_t w;
        int          slot;
        w = '0;
        for (int i = 0; i < GROUP_BITS; i++) begin
            slot = int'(grp) * GROUP_BITS + i;
            w[i] = (slot < FIRST_ALLOC_SLOT) || (slot >= TABLE_SLOTS);
        end
        return w;
    endfunction

    // in-use word written by the clearing pass
    function automatic group_word_t init_word(group_idx_t grp);
        group_word_t w;
        int          slot;
        w = '0;
        for (int i = 0; i < GROUP_BITS; i++) begin
            slot = int'(grp) * GROUP_BITS + i;
            w[i] = (slot < FIRST_ALLOC_SLOT);
        end
        return w;
    endfunction

    function automatic zero_find_t lowest_zero(group_word_t w);
        zero_find_t r;
        r = '0;
        for (int i = GROUP_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r.found = 1'b1;
                r.idx   = GROUP_IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== design/dsa_ram.sv =====
module dsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/descriptor_slot_allocator_core.sv =====
// descriptor slot allocator: a table of 256 descriptor slots, each with an in-use bit and a
// 64-bit handle. slots 0 to 2 start in use and serve the three std handle registers live;
// allocate takes the lowest free slot from 3 upward, lookup reads a slot, free clears it.
// every request gives exactly one result transfer. the in-use bits sit in a ram of 16-bit
// group words with a per-group full flag in flops, and the handles in a 64-bit ram. an item
// is accepted, then executed: the accept cycle searches the full flags and issues both
// ram reads, the next cycle finds the bit inside the group word, writes back and loads the
// output register; that cycle is held while the output register still carries an untaken
// result. after reset the in-use ram is swept once, one group word a cycle, with s_tready
// low; configuration writes are taken at any time
module descriptor_slot_allocator_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]         cfg_wr_index,
    input  logic [dsa_pkg::HANDLE_W-1:0]          cfg_wr_data,

    // request channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [dsa_pkg::S_TDATA_W-1:0]         s_tdata,   // descriptor[9:0], handle_word[73:10]
    input  logic [dsa_pkg::OP_W-1:0]              s_tuser,   // operation[1:0]

    // result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [dsa_pkg::M_TDATA_W-1:0]         m_tdata,   // slot_index[8:0], stored_handle[72:9]
    output logic [dsa_pkg::STATUS_W-1:0]          m_tuser    // status[1:0]
);

    // std handle registers
    logic [dsa_pkg::HANDLE_W-1:0] std_in_reg;
    logic [dsa_pkg::HANDLE_W-1:0] std_out_reg;
    logic [dsa_pkg::HANDLE_W-1:0] std_err_reg;

    // control state
    dsa_pkg::state_t              state_reg, state_next;
    dsa_pkg::group_idx_t          clr_cnt_reg, clr_cnt_next;
    logic [dsa_pkg::GROUPS-1:0]   group_full_reg, group_full_next;
    logic                         m_tvalid_reg, m_tvalid_next;

    // request held for the execute cycle
    dsa_pkg::op_t                      op_reg;
    logic [dsa_pkg::PAD_SLOT_W-1:0]    desc_slot_reg;
    logic                              in_range_reg;
    logic [dsa_pkg::HANDLE_W-1:0]      hw_reg;
    dsa_pkg::group_idx_t               grp_reg;
    logic                              alloc_none_reg;

    // result register
    logic [dsa_pkg::INDEX_W-1:0]       m_index_reg, m_index_next;
    logic [dsa_pkg::HANDLE_W-1:0]      m_handle_reg, m_handle_next;
    dsa_pkg::status_t                  m_status_reg, m_status_next;

    // request fields
    dsa_pkg::op_t                      s_op;
    logic [dsa_pkg::DESC_W-1:0]        s_desc;
    logic [dsa_pkg::HANDLE_W-1:0]      s_hw;
    logic                              s_in_range;
    logic [dsa_pkg::PAD_SLOT_W-1:0]    s_slot;
    logic                              s_xfer;

    // lowest non-full group
    dsa_pkg::group_idx_t               free_grp;
    logic                              free_grp_found;

    // ram ports
    logic                              bm_we, bm_re;
    dsa_pkg::group_idx_t               bm_waddr, bm_raddr;
    dsa_pkg::group_word_t              bm_wdata, bm_rdata;
    logic                              hd_we, hd_re;
    logic [dsa_pkg::SLOT_W-1:0]        hd_waddr, hd_raddr;
    logic [dsa_pkg::HANDLE_W-1:0]      hd_rdata;

    // execute cycle
    dsa_pkg::group_word_t              masked_word;
    dsa_pkg::zero_find_t               lz;
    logic [dsa_pkg::PAD_SLOT_W-1:0]    alloc_slot;
    logic                              alloc_full;
    logic                              slot_bit;
    logic [dsa_pkg::HANDLE_W-1:0]      fixed_handle;
    logic                              out_free;

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    assign s_op       = dsa_pkg::op_t'(s_tuser);
    assign s_desc     = s_tdata[dsa_pkg::DESC_W-1:0];
    assign s_hw       = s_tdata[dsa_pkg::DESC_W +: dsa_pkg::HANDLE_W];
    // negative or past the table end is out of range
    assign s_in_range = !s_desc[dsa_pkg::DESC_W-1]
                        && (32'(s_desc[dsa_pkg::DESC_W-2:0]) < 32'(dsa_pkg::TABLE_SLOTS));
    assign s_slot     = dsa_pkg::PAD_SLOT_W'(s_desc[dsa_pkg::DESC_W-2:0]);
    assign s_tready   = (state_reg == dsa_pkg::S_IDLE);
    assign s_xfer     = s_tvalid && s_tready;

    // first group with a free allocatable slot
    always_comb begin
        free_grp       = '0;
        free_grp_found = 1'b0;
        for (int g = dsa_pkg::GROUPS - 1; g >= 0; g--) begin
            if (!group_full_reg[g]) begin
                free_grp       = dsa_pkg::GRP_W'(g);
                free_grp_found = 1'b1;
            end
        end
    end

    assign bm_re    = s_xfer;
    assign bm_raddr = (s_op == dsa_pkg::OP_ALLOC)
                      ? free_grp : s_slot[dsa_pkg::PAD_SLOT_W-1:dsa_pkg::GROUP_IDX_W];
    assign hd_re    = s_xfer;
    assign hd_raddr = s_slot[dsa_pkg::SLOT_W-1:0];

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    dsa_ram #(
        .WIDTH (dsa_pkg::GROUP_BITS),
        .DEPTH (dsa_pkg::GROUPS)
    ) u_inuse_ram (
        .clk   (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    dsa_ram #(
        .WIDTH (dsa_pkg::HANDLE_W),
        .DEPTH (dsa_pkg::TABLE_SLOTS)
    ) u_handle_ram (
        .clk   (aclk),
        .we    (hd_we),
        .waddr (hd_waddr),
        .wdata (hw_reg),
        .re    (hd_re),
        .raddr (hd_raddr),
        .rdata (hd_rdata)
    );

    // ------------------------------------------------------------------
    // execute cycle: bit search inside the group and read-modify-write
    // ------------------------------------------------------------------
    assign masked_word = bm_rdata | dsa_pkg::blocked_mask(grp_reg);
    assign lz          = dsa_pkg::lowest_zero(masked_word);
    assign alloc_slot  = {grp_reg, lz.idx};
    assign alloc_full  = alloc_none_reg || !lz.found;
    assign slot_bit    = bm_rdata[desc_slot_reg[dsa_pkg::GROUP_IDX_W-1:0]];
    assign out_free    = !m_tvalid_reg || m_tready;

    // slots 0 to 2 serve the config registers
    always_comb begin
        case (dsa_pkg::cfg_idx_t'(desc_slot_reg[dsa_pkg::CFG_IDX_W-1:0]))
            dsa_pkg::CFG_STD_INPUT:  fixed_handle = std_in_reg;
            dsa_pkg::CFG_STD_OUTPUT: fixed_handle = std_out_reg;
            dsa_pkg::CFG_STD_ERROR:  fixed_handle = std_err_reg;
            default:                 fixed_handle = '1;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        group_full_next = group_full_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_index_next    = m_index_reg;
        m_handle_next   = m_handle_reg;
        m_status_next   = m_status_reg;
        bm_we           = 1'b0;
        bm_waddr        = grp_reg;
        bm_wdata        = bm_rdata;
        hd_we           = 1'b0;
        hd_waddr        = alloc_slot[dsa_pkg::SLOT_W-1:0];

        unique case (state_reg)
            dsa_pkg::S_CLEAR: begin
                // one group word per cycle
                bm_we        = 1'b1;
                bm_waddr     = clr_cnt_reg;
                bm_wdata     = dsa_pkg::init_word(clr_cnt_reg);
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == dsa_pkg::GRP_W'(dsa_pkg::GROUPS - 1)) begin
                    state_next = dsa_pkg::S_IDLE;
                end
            end
            dsa_pkg::S_IDLE: begin
                if (s_xfer) begin
                    state_next = dsa_pkg::S_EXEC;
                end
            end
            dsa_pkg::S_EXEC: begin
                if (out_free) begin
                    state_next    = dsa_pkg::S_IDLE;
                    m_tvalid_next = 1'b1;
                    m_index_next  = '1;
                    m_handle_next = '1;
                    m_status_next = dsa_pkg::STAT_RANGE;
                    case (op_reg)
                        dsa_pkg::OP_ALLOC: begin
                            if (alloc_full) begin
                                m_status_next = dsa_pkg::STAT_FULL;
                            end else begin
                                m_index_next  = dsa_pkg::INDEX_W'(alloc_slot);
                                m_handle_next = hw_reg;
                                m_status_next = dsa_pkg::STAT_OK;
                                // the invalid handle reports a slot but leaves it free
                                if (hw_reg != '1) begin
                                    bm_we    = 1'b1;
                                    bm_wdata = bm_rdata
                                               | (dsa_pkg::group_word_t'(1) << lz.idx);
                                    hd_we    = 1'b1;
                                end
                            end
                        end
                        dsa_pkg::OP_LOOKUP: begin
                            if (in_range_reg) begin
                                m_index_next = dsa_pkg::INDEX_W'(desc_slot_reg);
                                if (!slot_bit) begin
                                    m_status_next = dsa_pkg::STAT_EMPTY;
                                end else begin
                                    m_status_next = dsa_pkg::STAT_OK;
                                    if (32'(desc_slot_reg) < 32'(dsa_pkg::FIRST_ALLOC_SLOT)) begin
                                        m_handle_next = fixed_handle;
                                    end else begin
                                        m_handle_next = hd_rdata;
                                    end
                                end
                            end
                        end
                        dsa_pkg::OP_FREE: begin
                            if (in_range_reg) begin
                                m_index_next  = dsa_pkg::INDEX_W'(desc_slot_reg);
                                m_status_next = dsa_pkg::STAT_OK;
                                bm_we         = 1'b1;
                                bm_wdata      = bm_rdata
                                                & ~(dsa_pkg::group_word_t'(1)
                                                    << desc_slot_reg[dsa_pkg::GROUP_IDX_W-1:0]);
                            end
                        end
                        default: begin
                            // unused op code: range status, no change
                        end
                    endcase
                    if (bm_we) begin
                        group_full_next[grp_reg] =
                            &(bm_wdata | dsa_pkg::blocked_mask(grp_reg));
                    end
                end
            end
            default: begin
                state_next = dsa_pkg::S_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dsa_pkg::S_CLEAR;
            clr_cnt_reg    <= '0;
            group_full_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            std_in_reg     <= '0;
            std_out_reg    <= '0;
            std_err_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            group_full_reg <= group_full_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (dsa_pkg::cfg_idx_t'(cfg_wr_index))
                    dsa_pkg::CFG_STD_INPUT:  std_in_reg  <= cfg_wr_data;
                    dsa_pkg::CFG_STD_OUTPUT: std_out_reg <= cfg_wr_data;
                    dsa_pkg::CFG_STD_ERROR:  std_err_reg <= cfg_wr_data;
                    default: begin
                        // index past the register list is dropped
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg         <= s_op;
            desc_slot_reg  <= s_slot;
            in_range_reg   <= s_in_range;
            hw_reg         <= s_hw;
            grp_reg        <= bm_raddr;
            alloc_none_reg <= !free_grp_found;
        end
        m_index_reg  <= m_index_next;
        m_handle_reg <= m_handle_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = dsa_pkg::M_TDATA_W'({m_handle_reg, m_index_reg});
    assign m_tuser  = m_status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == dsa_pkg::S_EXEC))
        else $error("accepted request did not move to execute");

    a_alloc_above_fixed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dsa_pkg::S_EXEC && out_free && op_reg == dsa_pkg::OP_ALLOC
         && !alloc_full)
        |-> (32'(alloc_slot) >= 32'(dsa_pkg::FIRST_ALLOC_SLOT)))
        else $error("allocate picked a fixed slot");

    a_single_bit_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dsa_pkg::S_EXEC && bm_we)
        |-> ($countones(bm_wdata ^ bm_rdata) <= 1))
        else $error("in-use update touched more than one slot");

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dsa_pkg::S_CLEAR) |-> (!m_tvalid_reg && !s_tready))
        else $error("traffic during clearing pass");

endmodule
